// ===== rtl/rnb_pkg.sv =====
package rnb_pkg;

  // Field widths fixed by the pixel format and the register map.
  // The input row count runs one row past the height while a frame drains, so
  // the row counters carry one bit more than the height register.
  localparam int CHAN_W       = 8;
  localparam int ROW_W        = 14;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Input operation codes.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Window geometry: three rows of three taps, oldest column on the left.
  localparam int WIN_SIZE    = 9;
  localparam int WIN_CENTRE  = 4;
  localparam int WIN_MID_NEW = 5;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One classified beat, handed from the front to the back.
  typedef struct packed {
    pixel_t pix;
    logic   up_en;
    logic   mid_en;
    logic   emit;
    logic   border;
    logic   last;
    logic   sel_mid;
  } job_t;

  // Sum of the eight neighbours of the centre, each divided by 8 first.
  function automatic logic [CHAN_W-1:0] neighbour_sum(
      input logic [WIN_SIZE-1:0][CHAN_W-1:0] taps);
    logic [CHAN_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      if (i != WIN_CENTRE) begin
        acc = acc + {3'b000, taps[i][CHAN_W-1:3]};
      end
    end
    return acc;
  endfunction

endpackage

// ===== rtl/rnb_queue.sv =====
module rnb_queue #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          full,
  output logic          empty
);
  import rnb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [NW-1:0] count;

  assign full     = (count == NW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[head];

  // Storage: written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + PW'(1);
      end
      if (pop) begin
        head <= (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/rnb_front.sv =====
module rnb_front #(
  parameter int CW = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [CW-1:0]             col_last,
  input  logic [rnb_pkg::ROW_W-1:0] height,
  input  logic [rnb_pkg::ROW_W-1:0] row_last,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  rnb_pkg::pixel_t           pix,
  input  logic                      q_full,
  output logic                      q_push,
  output rnb_pkg::job_t             q_job,
  output logic [CW-1:0]             q_col
);
  import rnb_pkg::*;

  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] in_row_next;
  logic [CW-1:0]    in_col;
  logic [CW-1:0]    in_col_next;
  logic [ROW_W-1:0] out_row;
  logic [ROW_W-1:0] out_row_next;
  logic [CW-1:0]    out_col;
  logic [CW-1:0]    out_col_next;

  logic accept;
  logic drain;
  logic frame_full;
  logic active;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign drain      = (op == OP_DRAIN);
  assign frame_full = (in_row >= height);

  // A push is taken until the frame is complete, a drain only after that.
  assign active = drain ? frame_full : !frame_full;
  assign q_push = accept && active;
  assign q_col  = in_col;

  // Classify the beat: line gating, whether it yields a pixel, border and end of frame.
  always_comb begin
    q_job.pix     = drain ? '0 : pix;
    q_job.up_en   = (in_row >= ROW_W'(2));
    q_job.mid_en  = (in_row != '0);
    q_job.emit    = drain || !((in_row == '0) || ((in_row == ROW_W'(1)) && (in_col == '0)));
    q_job.border  = (out_row == '0) || (out_row == row_last) ||
                    (out_col == '0) || (out_col == col_last);
    q_job.last    = (out_row == row_last) && (out_col == col_last);
    q_job.sel_mid = drain && (height == ROW_W'(1));
  end

  // Input and output position counters.
  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (restart) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
    end else if (q_push) begin
      if (in_col == col_last) begin
        in_col_next = '0;
        in_row_next = in_row + ROW_W'(1);
      end else begin
        in_col_next = in_col + CW'(1);
      end
      if (q_job.emit) begin
        if (q_job.last) begin
          in_row_next  = '0;
          in_col_next  = '0;
          out_row_next = '0;
          out_col_next = '0;
        end else if (out_col == col_last) begin
          out_col_next = '0;
          out_row_next = out_row + ROW_W'(1);
        end else begin
          out_col_next = out_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

endmodule

// ===== rtl/rnb_back.sv =====
module rnb_back #(
  parameter int LINE_MAX = 1024,
  parameter int CW       = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic                       q_empty,
  input  rnb_pkg::job_t              q_job,
  input  logic [CW-1:0]              q_col,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rnb_pkg::CHAN_W-1:0] out_red,
  output logic [rnb_pkg::CHAN_W-1:0] out_green,
  output logic [rnb_pkg::CHAN_W-1:0] out_blue,
  output logic                       frame_last
);
  import rnb_pkg::*;

  // Line stores: one write and one registered read per cycle each.
  pixel_t older_line [LINE_MAX];
  pixel_t newer_line [LINE_MAX];

  logic adv;

  // Read stage.
  logic          a_valid;
  job_t          a_job;
  logic [CW-1:0] a_col;
  pixel_t        rd_older;
  pixel_t        rd_newer;
  logic          fwd_hit;
  pixel_t        fwd_mid;
  pixel_t        fwd_pix;
  pixel_t        a_up;
  pixel_t        a_mid;

  // Window stage.
  pixel_t window_pixels [WIN_SIZE];
  logic   c_valid;
  logic   c_emit;
  logic   c_border;
  logic   c_last;
  logic   c_sel_mid;

  logic [WIN_SIZE-1:0][CHAN_W-1:0] taps_red;
  logic [WIN_SIZE-1:0][CHAN_W-1:0] taps_green;
  logic [WIN_SIZE-1:0][CHAN_W-1:0] taps_blue;
  pixel_t centre;
  pixel_t result;

  // The whole back moves when the output register is free or being taken.
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  // The item just ahead writes the same column when the row is one pixel wide.
  always_comb begin
    a_up  = '0;
    a_mid = '0;
    if (a_job.up_en) begin
      a_up = fwd_hit ? fwd_mid : rd_older;
    end
    if (a_job.mid_en) begin
      a_mid = fwd_hit ? fwd_pix : rd_newer;
    end
  end

  // Line store access: the leaving item writes, the entering item reads.
  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      older_line[a_col] <= a_mid;
      newer_line[a_col] <= a_job.pix;
    end
    if (q_pop) begin
      rd_older <= older_line[q_col];
      rd_newer <= newer_line[q_col];
      fwd_mid  <= a_mid;
      fwd_pix  <= a_job.pix;
      a_job    <= q_job;
      a_col    <= q_col;
    end
  end

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      a_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (adv) begin
      a_valid <= !q_empty;
      fwd_hit <= a_valid && (a_col == q_col);
    end
  end

  // Window shift: one column per item, new column on the right.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        window_pixels[i] <= '0;
      end
    end else if (adv && a_valid) begin
      for (int r = 0; r < 3; r++) begin
        window_pixels[r * 3]     <= window_pixels[r * 3 + 1];
        window_pixels[r * 3 + 1] <= window_pixels[r * 3 + 2];
      end
      window_pixels[2] <= a_up;
      window_pixels[5] <= a_mid;
      window_pixels[8] <= a_job.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_emit    <= a_job.emit;
      c_border  <= a_job.border;
      c_last    <= a_job.last;
      c_sel_mid <= a_job.sel_mid;
    end
  end

  // Border pixels pass through; interior pixels take the neighbour sum.
  always_comb begin
    for (int i = 0; i < WIN_SIZE; i++) begin
      taps_red[i]   = window_pixels[i].red;
      taps_green[i] = window_pixels[i].green;
      taps_blue[i]  = window_pixels[i].blue;
    end
    centre = c_sel_mid ? window_pixels[WIN_MID_NEW] : window_pixels[WIN_CENTRE];
    if (c_border) begin
      result = centre;
    end else begin
      result.red   = neighbour_sum(taps_red);
      result.green = neighbour_sum(taps_green);
      result.blue  = neighbour_sum(taps_blue);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid && c_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red    <= result.red;
      out_green  <= result.green;
      out_blue   <= result.blue;
      frame_last <= c_last;
    end
  end

endmodule

// ===== rtl/rgb_neighbour_blur_3x3_core.sv =====
// 3x3 neighbour blur over RGB frames in raster order.
// Input channel (in_valid / in_stall): op 0 pushes one pixel, op 1 drains one
// pending output once the whole frame has been pushed. Pushes after the frame
// is complete and drains before it is complete are taken and dropped.
// Output channel (out_valid / out_stall): one pixel per beat, frame_last set
// on the final pixel of the frame. Border pixels pass unchanged.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets
// the frame width, index 1 the frame height; a write restarts the frame and
// must only be issued while the block is idle.
// Latency: queue, read stage, window stage and output register; in the frame
// a result lags the input by one row plus one pixel, and drains flush the last
// row plus one pixel. Throughput is one beat per cycle while out_stall is low,
// set by each line store's one write and one read port, used once per beat.
// A four-entry queue sits between the classifying front and the window back;
// when out_stall is high the back holds, the queue fills and in_stall rises.
// Reset (rst, synchronous) restores width 1024 and height 768 and clears the
// counters and window; line store contents are not cleared.
module rgb_neighbour_blur_3x3_core #(
  parameter int LINE_MAX = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rnb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rnb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            op,
  input  logic [rnb_pkg::CHAN_W-1:0]      in_red,
  input  logic [rnb_pkg::CHAN_W-1:0]      in_green,
  input  logic [rnb_pkg::CHAN_W-1:0]      in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rnb_pkg::CHAN_W-1:0]      out_red,
  output logic [rnb_pkg::CHAN_W-1:0]      out_green,
  output logic [rnb_pkg::CHAN_W-1:0]      out_blue,
  output logic                            frame_last
);
  import rnb_pkg::*;

  localparam int CW = $clog2(LINE_MAX);
  localparam int EW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
  localparam int QW = $bits(job_t) + CW;

  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic                    cfg_write;
  logic                    restart;

  logic [EW-1:0]    width_ext;
  logic [EW-1:0]    width_eff;
  logic [EW-1:0]    width_m1;
  logic [CW-1:0]    col_last;
  logic [ROW_W-1:0] height_eff;
  logic [ROW_W-1:0] row_last;

  pixel_t        in_pix;
  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  job_t          f_job;
  logic [CW-1:0] f_col;
  job_t          b_job;
  logic [CW-1:0] b_col;
  logic [QW-1:0] push_data;
  logic [QW-1:0] pop_data;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write &&
                     ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_REG_W'(1024);
      frame_height <= HEIGHT_REG_W'(768);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, width is capped by the line store.
  assign width_ext = EW'(frame_width);
  always_comb begin
    if (frame_width == '0) begin
      width_eff = EW'(1);
    end else if (width_ext > EW'(LINE_MAX)) begin
      width_eff = EW'(LINE_MAX);
    end else begin
      width_eff = width_ext;
    end
  end
  assign width_m1   = width_eff - EW'(1);
  assign col_last   = width_m1[CW-1:0];
  assign height_eff = (frame_height == '0) ? ROW_W'(1) : ROW_W'(frame_height);
  assign row_last   = height_eff - ROW_W'(1);

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;

  rnb_front #(
    .CW (CW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .col_last (col_last),
    .height   (height_eff),
    .row_last (row_last),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .pix      (in_pix),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (f_job),
    .q_col    (f_col)
  );

  assign push_data      = {f_job, f_col};
  assign {b_job, b_col} = pop_data;

  rnb_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rnb_back #(
    .LINE_MAX (LINE_MAX),
    .CW       (CW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .q_empty    (q_empty),
    .q_job      (b_job),
    .q_col      (b_col),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_last (frame_last)
  );

endmodule

// ===== dv/rgb_neighbour_blur_3x3_core_test.sv =====
`timescale 1ns / 1ps

module rgb_neighbour_blur_3x3_core_test;
  import rnb_pkg::*;

  localparam int          LINE_MAX    = 1024;
  localparam int          ITEM_GOAL   = 1750;
  localparam int          WIDE_PUSHES = 1040;
  localparam int          SETTLE      = 16;
  localparam int          END_WAIT    = 32;
  localparam int          LONG_HOLD   = 200;
  localparam int          PRINT_CAP   = 100;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // Index with no register behind it; a write to it changes nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } blur_out_t;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  // One row of the directed table: a register write or an input beat.
  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   opc;
    pixel_t                 pix;
    bit                     typed;
    bit                     want_valid;
    blur_out_t              want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   op = OP_PUSH;
  logic [CHAN_W-1:0]      in_red = '0;
  logic [CHAN_W-1:0]      in_green = '0;
  logic [CHAN_W-1:0]      in_blue = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CHAN_W-1:0]      out_red;
  logic [CHAN_W-1:0]      out_green;
  logic [CHAN_W-1:0]      out_blue;
  logic                   frame_last;

  rgb_neighbour_blur_3x3_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_last (frame_last)
  );

  // Blur predictor state: registers, line stores, window and frame position.
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  pixel_t                  older_store [LINE_MAX];
  pixel_t                  newer_store [LINE_MAX];
  pixel_t                  win [WIN_SIZE];
  int unsigned             in_row;
  int unsigned             in_col;
  int unsigned             out_row;
  int unsigned             out_col;

  blur_out_t   blur_expected [$];
  stim_row_t   plan [$];
  blur_out_t   oldest;
  int unsigned fail_count = 0;
  int unsigned beat_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_asked = 0;
  int unsigned hold_given = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    end
    fail_count++;
  endtask

  // Effective frame size after the out-of-range rules.
  function automatic int unsigned act_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned act_height();
    if (height_reg == 0) return 1;
    return 32'(height_reg);
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < WIN_SIZE; i++) begin
      win[i] = '0;
    end
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  // Slide the window one column and update both line stores.
  function automatic void shift_column(input pixel_t pix, input int unsigned w);
    int unsigned c;
    pixel_t      up;
    pixel_t      mid;
    c = (in_col >= LINE_MAX) ? 0 : in_col;
    up = (in_row >= 2) ? older_store[c] : '0;
    mid = (in_row >= 1) ? newer_store[c] : '0;
    for (int r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = up;
    win[WIN_MID_NEW] = mid;
    win[8] = pix;
    older_store[c] = mid;
    newer_store[c] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endfunction

  // Sum of the eight neighbours of one channel, each truncated to an eighth.
  function automatic logic [CHAN_W-1:0] neighbours_eighths(input int lsb);
    logic [CHAN_W-1:0] total;
    logic [23:0]       word;
    total = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      word = win[i];
      if (i != WIN_CENTRE) total = total + (word[lsb +: CHAN_W] >> 3);
    end
    return total;
  endfunction

  // Advance the predictor by one accepted beat; returns 1 when it yields a pixel.
  function automatic bit predict_blur(input logic opc, input pixel_t pix,
                                      output blur_out_t res);
    int unsigned w;
    int unsigned h;
    int unsigned received;
    pixel_t      centre;
    bit          border;
    w = act_width();
    h = act_height();
    res = '0;
    if (opc == OP_PUSH) begin
      if (in_row >= h) return 1'b0;
      received = in_row * w + in_col + 1;
      shift_column(pix, w);
      if (received < w + 2) return 1'b0;
      centre = win[WIN_CENTRE];
    end else begin
      if (in_row < h) return 1'b0;
      shift_column('0, w);
      // A single-row frame drains one column early.
      centre = (h == 1) ? win[WIN_MID_NEW] : win[WIN_CENTRE];
    end
    border = out_row == 0 || out_row == h - 1 || out_col == 0 || out_col == w - 1;
    res.last = (out_row == h - 1) && (out_col == w - 1);
    if (border) begin
      res.pix = centre;
    end else begin
      res.pix.red = neighbours_eighths(16);
      res.pix.green = neighbours_eighths(8);
      res.pix.blue = neighbours_eighths(0);
    end
    if (res.last) begin
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t rand_pixel();
    logic [23:0] bits;
    pixel_t      p;
    bits = 24'($urandom);
    p = bits;
    if ($urandom_range(0, 4) == 0) begin
      p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  // Receiver: check each output beat and drive random stalls, with a long
  // hold whenever the sender asks for one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (blur_expected.size() == 0) begin
        report_mismatch($sformatf("pixel %h %h %h last %b with nothing expected",
                                  out_red, out_green, out_blue, frame_last));
      end else begin
        oldest = blur_expected.pop_front();
        if (out_red !== oldest.pix.red)
          report_mismatch($sformatf("red %h, expected %h", out_red, oldest.pix.red));
        if (out_green !== oldest.pix.green)
          report_mismatch($sformatf("green %h, expected %h", out_green, oldest.pix.green));
        if (out_blue !== oldest.pix.blue)
          report_mismatch($sformatf("blue %h, expected %h", out_blue, oldest.pix.blue));
        if (frame_last !== oldest.last)
          report_mismatch($sformatf("frame_last %b, expected %b", frame_last, oldest.last));
      end
    end
    if (hold_given != hold_asked) begin
      hold_given = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      stall_left = pick_pause() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Drop valid and wait until every predicted pixel has come out.
  task automatic idle_until_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blur_expected.size() != 0) @(posedge clk);
  endtask

  // Register write while the block is idle; the predictor follows at the beat.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    idle_until_empty();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = data[WIDTH_REG_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data[HEIGHT_REG_W-1:0];
        restart_frame();
      end
      default: begin
      end
    endcase
  endtask

  // Offer one input beat and, once taken, record what it should produce.
  task automatic send_beat(input logic opc, input pixel_t pix, input bit typed = 1'b0,
                           input bit want_valid = 1'b0, input blur_out_t want = '0);
    int unsigned gap;
    bit          taken;
    bit          has;
    blur_out_t   res;
    gap = (idle_on && $urandom_range(0, 99) < 40) ? pick_pause() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= opc;
    in_red <= pix.red;
    in_green <= pix.green;
    in_blue <= pix.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    taken = (opc == OP_PUSH) ? (in_row < act_height()) : (in_row >= act_height());
    has = predict_blur(opc, pix, res);
    if (typed) begin
      if (want_valid) blur_expected.push_back(want);
    end else if (has) begin
      blur_expected.push_back(res);
    end
    if (taken) beat_count++;
  endtask

  // One frame of random pixels with some noise, then the drain beats.
  task automatic push_frame(input int unsigned pixels, input bit may_cut, output bit cut);
    int unsigned cut_at;
    cut = 1'b0;
    cut_at = (may_cut && $urandom_range(0, 7) == 0) ? $urandom_range(0, pixels - 1) : pixels;
    for (int unsigned k = 0; k < pixels; k++) begin
      if (k == cut_at) begin
        cut = 1'b1;
        return;
      end
      // A drain inside the frame is dropped by the block.
      if ($urandom_range(0, 39) == 0) send_beat(OP_DRAIN, rand_pixel());
      if ($urandom_range(0, 199) == 0) idle_until_empty();
      send_beat(OP_PUSH, rand_pixel());
    end
    // A push once the frame is complete is dropped as well.
    if ($urandom_range(0, 9) == 0) send_beat(OP_PUSH, rand_pixel());
    while (in_row >= act_height()) send_beat(OP_DRAIN, rand_pixel());
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata,
                           input int frames, input bit may_cut, input bit hold);
    bit cut;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_FRAME_WIDTH, wdata);
      write_reg(REG_FRAME_HEIGHT, hdata);
    end else begin
      write_reg(REG_FRAME_HEIGHT, hdata);
      write_reg(REG_FRAME_WIDTH, wdata);
    end
    if (hold) hold_asked++;
    for (int f = 0; f < frames; f++) begin
      push_frame(act_width() * act_height(), may_cut, cut);
      if (cut) break;
    end
  endtask

  function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_WRITE, idx: idx, data: data, opc: OP_PUSH, pix: '0,
            typed: 1'b0, want_valid: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_beat(input logic opc, input pixel_t pix);
    stim_row_t row;
    row = '{kind: ROW_BEAT, idx: '0, data: '0, opc: opc, pix: pix,
            typed: 1'b0, want_valid: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_typed(input logic opc, input pixel_t pix, input bit want_valid,
                                    input pixel_t want_pix, input logic want_last);
    stim_row_t row;
    row = '{kind: ROW_BEAT, idx: '0, data: '0, opc: opc, pix: pix,
            typed: 1'b1, want_valid: want_valid, want: '{pix: want_pix, last: want_last}};
    plan.push_back(row);
  endfunction

  // Stimulus: directed table, a held-output phase, random frames, then the size extremes.
  initial begin
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] hdata;
    width_reg = 11'd1024;
    height_reg = 13'd768;
    restart_frame();

    // After reset: an early drain is dropped, a push starts a 1024-wide frame.
    add_typed(OP_DRAIN, 24'h000000, 1'b0, '0, 1'b0);
    add_typed(OP_PUSH, 24'hFFFFFF, 1'b0, '0, 1'b0);
    // One-pixel frame; a second push is dropped, the drain returns the pixel.
    add_write(REG_FRAME_WIDTH, 13'd1);
    add_write(REG_FRAME_HEIGHT, 13'd1);
    add_typed(OP_PUSH, 24'hFF0080, 1'b0, '0, 1'b0);
    add_typed(OP_PUSH, 24'h123456, 1'b0, '0, 1'b0);
    add_typed(OP_DRAIN, 24'h000000, 1'b1, 24'hFF0080, 1'b1);
    add_typed(OP_DRAIN, 24'hABCDEF, 1'b0, '0, 1'b0);
    add_write(REG_UNUSED, 13'h0AAA);
    // Smallest frame with an interior pixel, all channels at full scale.
    add_write(REG_FRAME_WIDTH, 13'd3);
    add_write(REG_FRAME_HEIGHT, 13'd3);
    for (int k = 0; k < 4; k++) add_typed(OP_PUSH, 24'hFFFFFF, 1'b0, '0, 1'b0);
    for (int k = 0; k < 4; k++) add_beat(OP_PUSH, 24'hFFFFFF);
    add_typed(OP_PUSH, 24'hFFFFFF, 1'b1, 24'hF8F8F8, 1'b0);
    for (int k = 0; k < 3; k++) add_beat(OP_DRAIN, 24'h000000);
    add_typed(OP_DRAIN, 24'h000000, 1'b1, 24'hFFFFFF, 1'b1);
    // Zero width and height both act as one.
    add_write(REG_FRAME_WIDTH, 13'd0);
    add_write(REG_FRAME_HEIGHT, 13'd0);
    add_typed(OP_PUSH, 24'h5A3CC3, 1'b0, '0, 1'b0);
    add_typed(OP_DRAIN, 24'h000000, 1'b1, 24'h5A3CC3, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].opc, plan[i].pix, plan[i].typed, plan[i].want_valid, plan[i].want);
      end
    end

    // Back-to-back beats against a long output hold, so the input stalls.
    beat_count = 0;
    idle_on = 1'b0;
    run_phase(13'd16, 13'd8, 1, 1'b0, 1'b1);
    idle_on = 1'b1;

    // Random frames, leaving room in the item budget for the wide rows.
    while (beat_count + WIDE_PUSHES < ITEM_GOAL) begin
      wdata = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(1, 2))
                                          : CFG_DATA_W'($urandom_range(3, 12));
      hdata = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(1, 2))
                                          : CFG_DATA_W'($urandom_range(3, 8));
      idle_on = ($urandom_range(0, 9) != 0);
      run_phase(wdata, hdata, $urandom_range(1, 3), 1'b1, 1'b0);
    end

    // Widest rows in a tall frame: an oversized width register acts as
    // the line length, so outputs begin one full line plus one pixel in.
    idle_on = 1'b1;
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    for (int k = 0; k < WIDE_PUSHES; k++) send_beat(OP_PUSH, rand_pixel());

    idle_until_empty();
    repeat (END_WAIT) @(posedge clk);
    if (blur_expected.size() != 0) begin
      report_mismatch($sformatf("%0d pixels never came out", blur_expected.size()));
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
